// File: rtl/core/dqkd_pkg.sv
// dual quadrature knob decoder package: shared constants, types and the step table
// used by dqkd_knob and dual_quadrature_knob_decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dqkd_pkg;

	localparam int SETTINGS_PER_KNOB = 8;
	localparam int SLOT_W = (SETTINGS_PER_KNOB > 1) ? $clog2(SETTINGS_PER_KNOB) : 1;

	localparam int SETTING_W = 3;
	localparam int VALUE_W   = 8;
	localparam int ACCUM_W   = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SETTING  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SETTING = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT   = CFG_IDX_W'(3);

	// detent move codes
	localparam logic [1:0] MOVE_NONE = 2'd0;
	localparam logic [1:0] MOVE_FWD  = 2'd1;
	localparam logic [1:0] MOVE_BACK = 2'd2;

	localparam logic [1:0] PINS_RESET = 2'b11;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         move;
	} knob_res_t;

	// transition table indexed by {prev A/B, cur A/B}: -1, 0 or +1
	function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
		logic signed [1:0] st;
		unique case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: st = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: st = 2'sd1;
			default: st = 2'sd0;
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/dqkd_knob.sv
// one knob: previous pin pair, detent accumulator and per-setting value store
// depends on dqkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqkd_knob (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step_en,
	input  wire logic [1:0]                      pins,
	input  wire logic [dqkd_pkg::SETTING_W-1:0]  setting,
	input  wire logic [dqkd_pkg::VALUE_W-1:0]    limit,
	output dqkd_pkg::knob_res_t                  res
);

	logic [1:0]                          prev_q;
	logic signed [dqkd_pkg::ACCUM_W-1:0] accum_q;
	logic [dqkd_pkg::VALUE_W-1:0]        values_q [dqkd_pkg::SETTINGS_PER_KNOB];

	logic [dqkd_pkg::SLOT_W-1:0]         slot;
	logic signed [1:0]                   st;
	logic signed [dqkd_pkg::ACCUM_W-1:0] sum;
	logic signed [dqkd_pkg::ACCUM_W-1:0] accum_nxt;
	logic [dqkd_pkg::VALUE_W-1:0]        cur;
	logic [dqkd_pkg::VALUE_W-1:0]        val_nxt;
	logic [1:0]                          move;

	always_comb begin
		// out-of-range setting saturates to the last slot
		if (int'(setting) >= dqkd_pkg::SETTINGS_PER_KNOB)
			slot = dqkd_pkg::SLOT_W'(dqkd_pkg::SETTINGS_PER_KNOB - 1);
		else
			slot = dqkd_pkg::SLOT_W'(setting);

		st  = dqkd_pkg::step_lookup({prev_q, pins});
		sum = accum_q + {{(dqkd_pkg::ACCUM_W-2){st[1]}}, st};
		cur = values_q[slot];

		val_nxt   = cur;
		accum_nxt = sum;
		move      = dqkd_pkg::MOVE_NONE;
		if (sum > 4'sd3) begin
			if (cur < limit)
				val_nxt = cur + dqkd_pkg::VALUE_W'(1);
			accum_nxt = '0;
			move      = dqkd_pkg::MOVE_FWD;
		end else if (sum < -4'sd3) begin
			if (cur != '0)
				val_nxt = cur - dqkd_pkg::VALUE_W'(1);
			accum_nxt = '0;
			move      = dqkd_pkg::MOVE_BACK;
		end

		res.value = val_nxt;
		res.move  = move;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= dqkd_pkg::PINS_RESET;
			accum_q <= '0;
			for (int i = 0; i < dqkd_pkg::SETTINGS_PER_KNOB; i++)
				values_q[i] <= '0;
		end else if (step_en) begin
			prev_q         <= pins;
			accum_q        <= accum_nxt;
			values_q[slot] <= val_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dual_quadrature_knob_decoder.sv
// dual quadrature knob decoder top level: config registers, input stage,
// two dqkd_knob instances and the result register; depends on dqkd_pkg, dqkd_knob
//
// usage:
// - input channel (in_valid/in_ready, pin_sample): one 4-bit pin sample per item,
//   bits 3..2 left knob A/B, bits 1..0 right knob A/B
// - output channel (out_valid/out_ready): one result item per input item with the
//   selected value of each knob, the move code of each knob and a changed flag
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0/1 left/right setting, 2/3 left/right limit, other indexes ignored;
//   write only while no item is in flight
// - path: out_valid rises once its item has passed the input register and
//   then the result register, where the result can be taken
// - throughput: one item per cycle while out_ready is high; the knob update
//   is a single table lookup, a 4-bit add and an 8-bit compare and increment
//   or decrement between the two registers
// - reset: pin history 2'b11, accumulators and all stored values zero,
//   settings 0, limits 255
// - when out_ready is low the result register holds, the input register
//   fills behind it and in_ready drops until the result is taken
`timescale 1ns / 1ps
`default_nettype none

module dual_quadrature_knob_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            cfg_valid,
	output wire logic                            cfg_ready,
	input  wire logic [dqkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dqkd_pkg::CFG_DAT_W-1:0]  cfg_data,

	input  wire logic                            in_valid,
	output wire logic                            in_ready,
	input  wire logic [3:0]                      pin_sample,

	output wire logic                            out_valid,
	input  wire logic                            out_ready,
	output wire logic [dqkd_pkg::VALUE_W-1:0]    left_value,
	output wire logic [dqkd_pkg::VALUE_W-1:0]    right_value,
	output wire logic [1:0]                      left_move,
	output wire logic [1:0]                      right_move,
	output wire logic                            changed
);

	logic [dqkd_pkg::SETTING_W-1:0] left_setting_q;
	logic [dqkd_pkg::SETTING_W-1:0] right_setting_q;
	logic [dqkd_pkg::VALUE_W-1:0]   left_limit_q;
	logic [dqkd_pkg::VALUE_W-1:0]   right_limit_q;

	logic        valid_s1;
	logic [3:0]  pins_s1;
	logic        out_valid_q;
	logic [dqkd_pkg::VALUE_W-1:0] left_value_q;
	logic [dqkd_pkg::VALUE_W-1:0] right_value_q;
	logic [1:0]  left_move_q;
	logic [1:0]  right_move_q;
	logic        changed_q;

	logic        advance;
	logic        fire_s1;
	dqkd_pkg::knob_res_t left_res;
	dqkd_pkg::knob_res_t right_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_setting_q  <= '0;
			right_setting_q <= '0;
			left_limit_q    <= '1;
			right_limit_q   <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dqkd_pkg::CFG_LEFT_SETTING:
					left_setting_q <= cfg_data[dqkd_pkg::SETTING_W-1:0];
				dqkd_pkg::CFG_RIGHT_SETTING:
					right_setting_q <= cfg_data[dqkd_pkg::SETTING_W-1:0];
				dqkd_pkg::CFG_LEFT_LIMIT:
					left_limit_q <= cfg_data[dqkd_pkg::VALUE_W-1:0];
				dqkd_pkg::CFG_RIGHT_LIMIT:
					right_limit_q <= cfg_data[dqkd_pkg::VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	// result register free or being drained this cycle
	assign advance  = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			pins_s1 <= pin_sample;
	end

	dqkd_knob u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (fire_s1),
		.pins    (pins_s1[3:2]),
		.setting (left_setting_q),
		.limit   (left_limit_q),
		.res     (left_res)
	);

	dqkd_knob u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (fire_s1),
		.pins    (pins_s1[1:0]),
		.setting (right_setting_q),
		.limit   (right_limit_q),
		.res     (right_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			left_value_q  <= left_res.value;
			right_value_q <= right_res.value;
			left_move_q   <= left_res.move;
			right_move_q  <= right_res.move;
			changed_q     <= (left_res.move != dqkd_pkg::MOVE_NONE) ||
				(right_res.move != dqkd_pkg::MOVE_NONE);
		end
	end

	assign out_valid   = out_valid_q;
	assign left_value  = left_value_q;
	assign right_value = right_value_q;
	assign left_move   = left_move_q;
	assign right_move  = right_move_q;
	assign changed     = changed_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for dual_quadrature_knob_decoder: streams pin samples through the block
// and checks every result against a knob decoder predictor kept in this file; needs dqkd_pkg
`timescale 1ns / 1ps

module tb;

	localparam logic [dqkd_pkg::CFG_IDX_W-1:0] CFG_PAST_END  = dqkd_pkg::CFG_IDX_W'(4);
	localparam logic [dqkd_pkg::CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;
	localparam int LEFT  = 0;
	localparam int RIGHT = 1;

	typedef struct {
		logic [dqkd_pkg::VALUE_W-1:0] lval;
		logic [dqkd_pkg::VALUE_W-1:0] rval;
		logic [1:0]         lmove;
		logic [1:0]         rmove;
		logic               chg;
	} knob_reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [dqkd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dqkd_pkg::CFG_DAT_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [3:0] pin_sample;
	logic out_valid;
	logic out_ready;
	logic [dqkd_pkg::VALUE_W-1:0] left_value;
	logic [dqkd_pkg::VALUE_W-1:0] right_value;
	logic [1:0] left_move;
	logic [1:0] right_move;
	logic changed;

	dual_quadrature_knob_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pin_sample(pin_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_value(left_value), .right_value(right_value),
		.left_move(left_move), .right_move(right_move), .changed(changed)
	);

	always #5 clk = ~clk;

	// predictor state, index 0 left knob, 1 right knob
	logic [1:0]         last_pins [2];
	int                 detent [2];
	logic [dqkd_pkg::SETTING_W-1:0] knob_sel [2];
	logic [dqkd_pkg::VALUE_W-1:0] knob_lim [2];
	logic [dqkd_pkg::VALUE_W-1:0] stored_val [2*dqkd_pkg::SETTINGS_PER_KNOB];

	// left detent forward, right detent backward held at zero,
	// then every pin combination including invalid jumps, then the reverse
	logic [3:0]    opening_pins [23] = '{4'h6, 4'h0, 4'h9, 4'hF, 4'h0, 4'hF, 4'h5, 4'hA,
		4'h3, 4'hC, 4'h1, 4'h2, 4'h4, 4'h7, 4'h8, 4'hB, 4'hD, 4'hE, 4'hF, 4'h9, 4'h0,
		4'h6, 4'hF};

	knob_reading_t knob_readings [$];
	logic [3:0]    pin_queue [$];
	logic [1:0]    cur_l, cur_r;
	bit            in_idle_on, out_idle_on;
	int            in_wait, out_wait;
	int            fail_count = 0;

	function automatic int quad_delta(input logic [3:0] tr);
		case (tr)
			4'd2, 4'd4, 4'd11, 4'd13: return 1;
			4'd1, 4'd7, 4'd8, 4'd14: return -1;
			default: return 0;
		endcase
	endfunction

	task automatic turn_knob(input int side, input logic [1:0] pins,
			output logic [dqkd_pkg::VALUE_W-1:0] val, output logic [1:0] mv);
		int slot;
		slot = (int'(knob_sel[side]) >= dqkd_pkg::SETTINGS_PER_KNOB) ?
			dqkd_pkg::SETTINGS_PER_KNOB - 1 : int'(knob_sel[side]);
		slot = side * dqkd_pkg::SETTINGS_PER_KNOB + slot;
		detent[side] = detent[side] + quad_delta({last_pins[side], pins});
		last_pins[side] = pins;
		mv = dqkd_pkg::MOVE_NONE;
		if (detent[side] > 3) begin
			if (stored_val[slot] < knob_lim[side])
				stored_val[slot] = stored_val[slot] + 1'b1;
			detent[side] = 0;
			mv = dqkd_pkg::MOVE_FWD;
		end else if (detent[side] < -3) begin
			if (stored_val[slot] != 0)
				stored_val[slot] = stored_val[slot] - 1'b1;
			detent[side] = 0;
			mv = dqkd_pkg::MOVE_BACK;
		end
		val = stored_val[slot];
	endtask

	task automatic predict_sample(input logic [3:0] pins);
		knob_reading_t r;
		turn_knob(LEFT, pins[3:2], r.lval, r.lmove);
		turn_knob(RIGHT, pins[1:0], r.rval, r.rmove);
		r.chg = (r.lmove != dqkd_pkg::MOVE_NONE) || (r.rmove != dqkd_pkg::MOVE_NONE);
		knob_readings.push_back(r);
	endtask

	function automatic int draw_gap(input bit on);
		if (!on || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// next pin pair of one knob: mostly quadrature steps, some holds and some noise
	function automatic logic [1:0] wander(input logic [1:0] p, input int bias);
		int r;
		bit fwd;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 2'($urandom_range(0, 3));
		if (r < 30)
			return p;
		fwd = ($urandom_range(0, 99) < bias);
		case (p)
			2'b11: return fwd ? 2'b01 : 2'b10;
			2'b01: return fwd ? 2'b00 : 2'b11;
			2'b00: return fwd ? 2'b10 : 2'b01;
			default: return fwd ? 2'b11 : 2'b00;
		endcase
	endfunction

	task automatic cmp_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	task automatic check_reading();
		knob_reading_t e;
		if (knob_readings.size() == 0) begin
			$display("%0t: result with no item outstanding, expected none actual %0d/%0d",
				$time, left_value, right_value);
			fail_count++;
		end else begin
			e = knob_readings.pop_front();
			cmp_field("left_value", e.lval, left_value);
			cmp_field("right_value", e.rval, right_value);
			cmp_field("left_move", e.lmove, left_move);
			cmp_field("right_move", e.rmove, right_move);
			cmp_field("changed", e.chg, changed);
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pin_sample <= 4'd0;
			in_wait <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_sample(pin_sample);
			if (in_valid && !in_ready) begin
				// hold the item until taken
			end else if (in_wait != 0) begin
				in_valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (pin_queue.size() != 0) begin
				pin_sample <= pin_queue.pop_front();
				in_valid <= 1'b1;
				in_wait <= draw_gap(in_idle_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
		end else begin
			stall = out_wait;
			if (out_valid && out_ready) begin
				check_reading();
				stall = draw_gap(out_idle_on);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				out_wait <= stall - 1;
			end else begin
				out_ready <= 1'b1;
				out_wait <= 0;
			end
		end
	end

	task automatic write_reg(input logic [dqkd_pkg::CFG_IDX_W-1:0] idx,
			input logic [dqkd_pkg::CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dqkd_pkg::CFG_LEFT_SETTING: knob_sel[LEFT] = data[dqkd_pkg::SETTING_W-1:0];
			dqkd_pkg::CFG_RIGHT_SETTING: knob_sel[RIGHT] = data[dqkd_pkg::SETTING_W-1:0];
			dqkd_pkg::CFG_LEFT_LIMIT: knob_lim[LEFT] = data;
			dqkd_pkg::CFG_RIGHT_LIMIT: knob_lim[RIGHT] = data;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pin_queue.size() != 0 || in_valid || knob_readings.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] lsel, input logic [7:0] rsel,
			input logic [7:0] llim, input logic [7:0] rlim, input int n,
			input int lbias, input int rbias, input bit iidle, input bit oidle);
		write_reg(dqkd_pkg::CFG_LEFT_SETTING, lsel);
		write_reg(dqkd_pkg::CFG_RIGHT_SETTING, rsel);
		write_reg(dqkd_pkg::CFG_LEFT_LIMIT, llim);
		write_reg(dqkd_pkg::CFG_RIGHT_LIMIT, rlim);
		cfg_valid <= 1'b0;
		in_idle_on = iidle;
		out_idle_on = oidle;
		repeat (n) begin
			cur_l = wander(cur_l, lbias);
			cur_r = wander(cur_r, rbias);
			pin_queue.push_back({cur_l, cur_r});
		end
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < 2; i++) begin
			last_pins[i] = dqkd_pkg::PINS_RESET;
			detent[i] = 0;
			knob_sel[i] = '0;
			knob_lim[i] = '1;
		end
		foreach (stored_val[i])
			stored_val[i] = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_pins[i])
			pin_queue.push_back(opening_pins[i]);
		wait_idle();
		cur_l = 2'b11;
		cur_r = 2'b11;

		// upper setting bits are dropped, so 8'hFB selects setting 3
		run_phase(8'hFB, 8'h04, 8'hFF, 8'hFF, 200, 90, 10, 1'b1, 1'b1);
		// limit under the stored value: no increment
		run_phase(8'd3, 8'd4, 8'd5, 8'd0, 150, 70, 80, 1'b0, 1'b0);
		run_phase(8'd3, 8'd7, 8'd5, 8'hFF, 150, 10, 90, 1'b1, 1'b1);
		run_phase(8'd0, 8'd0, 8'd2, 8'd3, 150, 50, 50, 1'b1, 1'b1);
		write_reg(CFG_PAST_END, 8'hAA);
		write_reg(CFG_TOP_INDEX, 8'h55);
		run_phase(8'd7, 8'd0, 8'hFF, 8'd128, 150, 85, 15, 1'b1, 1'b0);
		run_phase(8'd5, 8'd6, 8'd1, 8'd254, 150, 60, 40, 1'b1, 1'b0);
		run_phase(8'd7, 8'd7, 8'hFF, 8'hFF, 150, 95, 95, 1'b0, 1'b1);
		run_phase(8'd2, 8'd1, 8'd10, 8'd10, 150, 30, 75, 1'b1, 1'b1);
		run_phase(8'd3, 8'd7, 8'd0, 8'd0, 100, 80, 20, 1'b1, 1'b1);

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", knob_readings.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
